### hw/rtl/aet_pkg.sv
// Shared types, constants and character helpers for the expression tokenizer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package aet_pkg;

  localparam int MAX_NUMBER_CHARS_DEF = 8;
  localparam int QUEUE_DEPTH          = 2;
  localparam int PADDR_W              = 3;

  localparam logic [3:0] MAX_WORD_RESET = 4'd4;

  // register index decoded from paddr[2]
  localparam logic REG_MAX_WORD_LENGTH = 1'b0;

  typedef enum logic [3:0] {
    KIND_NUMBER = 4'd0,
    KIND_PLUS   = 4'd1,
    KIND_MINUS  = 4'd2,
    KIND_TIMES  = 4'd3,
    KIND_DIVIDE = 4'd4,
    KIND_LPAREN = 4'd5,
    KIND_RPAREN = 4'd6,
    KIND_SQRT   = 4'd7,
    KIND_SIN    = 4'd8,
    KIND_COS    = 4'd9,
    KIND_TAN    = 4'd10,
    KIND_EOF    = 4'd11
  } kind_t;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;

  // keywords packed first letter in the low byte
  localparam logic [31:0] KW_SQRT = 32'h7472_7173;
  localparam logic [31:0] KW_SIN  = 32'h006E_6973;
  localparam logic [31:0] KW_COS  = 32'h0073_6F63;
  localparam logic [31:0] KW_TAN  = 32'h006E_6174;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } aet_char_t;

  typedef struct packed {
    kind_t       token_kind;
    logic [63:0] number_text;
    logic [3:0]  text_length;
    logic        invalid_text;
    logic        last_of_run;
  } aet_token_t;

  // up to two tokens caused by one input item: a number, then any other token
  typedef struct packed {
    logic        has_number;
    logic [63:0] number_text;
    logic [3:0]  text_length;
    logic        has_other;
    kind_t       other_kind;
    logic        other_invalid;
  } aet_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } aet_qstat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

  // KIND_NUMBER means the character is no operator
  function automatic kind_t op_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_TIMES;
      CH_SLASH:  k = KIND_DIVIDE;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      default:   k = KIND_NUMBER;
    endcase
    return k;
  endfunction

  // KIND_NUMBER means no keyword matched
  function automatic kind_t keyword_kind(input logic [31:0] buf_w, input logic [4:0] len);
    kind_t k;
    k = KIND_NUMBER;
    if (len == 5'd4 && buf_w == KW_SQRT) k = KIND_SQRT;
    else if (len == 5'd3 && buf_w == KW_SIN) k = KIND_SIN;
    else if (len == 5'd3 && buf_w == KW_COS) k = KIND_COS;
    else if (len == 5'd3 && buf_w == KW_TAN) k = KIND_TAN;
    return k;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/arith_expression_tokenizer.sv
// Arithmetic expression tokenizer: lexer front end, entry queue, output side.
// Accepts one character per cycle while the queue is not full; every token is
// registered in the queue; one item's number and second token go out in turn.
// The two-entry queue lets the front end run while the output is stalled.
// Synchronous reset clears lexer state and queue and sets max_word_length to 4.
`timescale 1ns / 1ps
`default_nettype none

module arith_expression_tokenizer #(
  parameter int MAX_NUMBER_CHARS = aet_pkg::MAX_NUMBER_CHARS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          char_valid,
  output logic                         char_stall,
  input  aet_pkg::aet_char_t           char_item,
  output logic                         token_valid,
  input  wire                          token_stall,
  output aet_pkg::aet_token_t          token_item,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [aet_pkg::PADDR_W-1:0]   paddr,
  input  wire [31:0]                   pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import aet_pkg::*;

  logic [3:0] max_word_length;
  logic       cfg_write;
  logic       push, pop;
  aet_entry_t push_entry, head;
  aet_qstat_t qstat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_WORD_LENGTH);
  assign prdata    = (paddr[2] == REG_MAX_WORD_LENGTH) ? {28'd0, max_word_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_word_length <= MAX_WORD_RESET;
    end else if (cfg_write) begin
      max_word_length <= pwdata[3:0];
    end
  end

  aet_front #(
    .MAX_NUMBER_CHARS(MAX_NUMBER_CHARS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .char_valid     (char_valid),
    .char_stall     (char_stall),
    .char_item      (char_item),
    .max_word_length(max_word_length),
    .qstat          (qstat),
    .push           (push),
    .push_entry     (push_entry)
  );

  aet_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  aet_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .token_item (token_item)
  );

endmodule

`default_nettype wire

### hw/rtl/aet_front.sv
// Front end of the tokenizer (uses aet_pkg): takes one character per cycle
// while not stalled, runs the lexer FSM and pushes its tokens as one queue entry.
`timescale 1ns / 1ps
`default_nettype none

module aet_front #(
  parameter int MAX_NUMBER_CHARS = aet_pkg::MAX_NUMBER_CHARS_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      char_valid,
  output logic                     char_stall,
  input  aet_pkg::aet_char_t       char_item,
  input  wire [3:0]                max_word_length,
  input  aet_pkg::aet_qstat_t      qstat,
  output logic                     push,
  output aet_pkg::aet_entry_t      push_entry
);
  import aet_pkg::*;

  localparam int NB = 8 * MAX_NUMBER_CHARS;
  localparam int CW = $clog2(MAX_NUMBER_CHARS + 1);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_WORD,
    MODE_INVALID
  } mode_t;

  mode_t          mode, mode_next;
  logic [NB-1:0]  num_buf, num_buf_next;
  logic [CW-1:0]  num_cnt, num_cnt_next;
  logic           dot_seen, dot_seen_next;
  logic [31:0]    word_buf, word_buf_next;
  logic [3:0]     word_cnt, word_cnt_next;

  logic [7:0]  c;
  logic        accept;
  logic        c_dig, c_let, c_dot;
  kind_t       opk, kw;
  logic        word_cont;
  logic [31:0] wbase_buf, wnew;
  logic [3:0]  wbase_cnt;
  logic [4:0]  wlen;
  logic        run_fresh, run_word;
  logic        emit_num, emit_oth, oth_inv;
  kind_t       oth_kind;

  assign c          = char_item.char_code;
  assign char_stall = qstat.full;
  assign accept     = char_valid && !qstat.full;

  assign c_dig = is_digit(c);
  assign c_let = is_letter(c);
  assign c_dot = (c == CH_DOT);
  assign opk   = op_kind(c);

  // word path: continue the current word or start a fresh one
  assign word_cont = (mode == MODE_WORD) && c_let;
  assign wbase_buf = word_cont ? word_buf : 32'd0;
  assign wbase_cnt = word_cont ? word_cnt : 4'd0;
  assign wlen      = {1'b0, wbase_cnt} + 5'd1;

  always_comb begin
    wnew = wbase_buf;
    for (int i = 0; i < 4; i++) begin
      if (wbase_cnt == 4'(i)) wnew[8*i +: 8] = c;
    end
  end

  assign kw = keyword_kind(wnew, wlen);

  always_comb begin
    mode_next     = mode;
    num_buf_next  = num_buf;
    num_cnt_next  = num_cnt;
    dot_seen_next = dot_seen;
    word_buf_next = word_buf;
    word_cnt_next = word_cnt;
    emit_num      = 1'b0;
    emit_oth      = 1'b0;
    oth_kind      = KIND_EOF;
    oth_inv       = 1'b0;
    run_fresh     = 1'b0;
    run_word      = 1'b0;

    if (char_item.end_of_text) begin
      emit_num      = (mode == MODE_NUMBER);
      emit_oth      = 1'b1;
      oth_kind      = KIND_EOF;
      oth_inv       = (mode == MODE_INVALID);
      mode_next     = MODE_IDLE;
      num_buf_next  = '0;
      num_cnt_next  = '0;
      dot_seen_next = 1'b0;
      word_buf_next = '0;
      word_cnt_next = '0;
    end else begin
      case (mode)
        MODE_NUMBER: begin
          if (c_dig || c_dot) begin
            if ((c_dot && dot_seen) || (num_cnt >= CW'(MAX_NUMBER_CHARS))) begin
              mode_next = MODE_INVALID;
            end else begin
              for (int i = 0; i < MAX_NUMBER_CHARS; i++) begin
                if (num_cnt == CW'(i)) num_buf_next[8*i +: 8] = c;
              end
              num_cnt_next = num_cnt + CW'(1);
              if (c_dot) dot_seen_next = 1'b1;
            end
          end else begin
            // flush the number, then treat the ending character afresh
            emit_num      = 1'b1;
            mode_next     = MODE_IDLE;
            num_buf_next  = '0;
            num_cnt_next  = '0;
            dot_seen_next = 1'b0;
            run_fresh     = 1'b1;
          end
        end
        MODE_WORD: begin
          if (c_let) begin
            run_word = 1'b1;
          end else begin
            mode_next     = MODE_IDLE;
            word_buf_next = '0;
            word_cnt_next = '0;
            run_fresh     = 1'b1;
          end
        end
        MODE_IDLE: begin
          run_fresh = 1'b1;
        end
        default: begin
        end
      endcase

      if (run_fresh) begin
        if (opk != KIND_NUMBER) begin
          emit_oth = 1'b1;
          oth_kind = opk;
        end else if (c_dig) begin
          mode_next    = MODE_NUMBER;
          num_buf_next = NB'(c);
          num_cnt_next = CW'(1);
        end else if (c_let) begin
          run_word = 1'b1;
        end
      end

      if (run_word) begin
        if (kw != KIND_NUMBER) begin
          emit_oth      = 1'b1;
          oth_kind      = kw;
          mode_next     = MODE_IDLE;
          word_buf_next = '0;
          word_cnt_next = '0;
        end else if (wlen > {1'b0, max_word_length}) begin
          mode_next = MODE_INVALID;
        end else begin
          mode_next     = MODE_WORD;
          word_buf_next = wnew;
          word_cnt_next = wlen[3:0];
        end
      end
    end
  end

  assign push                     = accept && (emit_num || emit_oth);
  assign push_entry.has_number    = emit_num;
  assign push_entry.number_text   = 64'(num_buf);
  assign push_entry.text_length   = 4'(num_cnt);
  assign push_entry.has_other     = emit_oth;
  assign push_entry.other_kind    = oth_kind;
  assign push_entry.other_invalid = oth_inv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      num_buf  <= '0;
      num_cnt  <= '0;
      dot_seen <= 1'b0;
      word_buf <= '0;
      word_cnt <= '0;
    end else if (accept) begin
      mode     <= mode_next;
      num_buf  <= num_buf_next;
      num_cnt  <= num_cnt_next;
      dot_seen <= dot_seen_next;
      word_buf <= word_buf_next;
      word_cnt <= word_cnt_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/aet_queue.sv
// Short queue of token entries between the lexer front end and the output side.
// Uses aet_pkg for the entry and status types.
`timescale 1ns / 1ps
`default_nettype none

module aet_queue (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      push,
  input  aet_pkg::aet_entry_t      push_entry,
  input  wire                      pop,
  output aet_pkg::aet_entry_t      head,
  output aet_pkg::aet_qstat_t      qstat
);
  import aet_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  aet_entry_t    slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count;
  logic          do_push, do_pop;

  assign qstat.full  = (count == NW'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) count <= count + NW'(1);
      else if (do_pop && !do_push) count <= count - NW'(1);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/aet_back.sv
// Output side of the tokenizer: splits each queue entry into one or two token
// items and presents them on the output channel. Uses aet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aet_back (
  input  wire                      clk,
  input  wire                      rst,
  input  aet_pkg::aet_entry_t      head,
  input  aet_pkg::aet_qstat_t      qstat,
  output logic                     pop,
  output logic                     token_valid,
  input  wire                      token_stall,
  output aet_pkg::aet_token_t      token_item
);
  import aet_pkg::*;

  logic phase;
  logic second;
  logic accept;

  // number goes out first; the other token follows it
  assign second      = phase || !head.has_number;
  assign token_valid = !qstat.empty;
  assign accept      = token_valid && !token_stall;
  assign pop         = accept && (second || !head.has_other);

  always_comb begin
    if (second) begin
      token_item.token_kind   = head.other_kind;
      token_item.number_text  = 64'd0;
      token_item.text_length  = 4'd0;
      token_item.invalid_text = head.other_invalid;
      token_item.last_of_run  = 1'b1;
    end else begin
      token_item.token_kind   = KIND_NUMBER;
      token_item.number_text  = head.number_text;
      token_item.text_length  = head.text_length;
      token_item.invalid_text = 1'b0;
      token_item.last_of_run  = !head.has_other;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (accept) begin
      phase <= !second && head.has_other;
    end
  end

endmodule

`default_nettype wire
